// ===== rtl/flow_sequence_loss_monitor_defines.svh =====
// assertion macros, sampled on clk and quiet while arst_n is low
`ifndef FLOW_SEQUENCE_LOSS_MONITOR_DEFINES_SVH
`define FLOW_SEQUENCE_LOSS_MONITOR_DEFINES_SVH

// consequent holds in the same cycle
`define FSLM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the next cycle
`define FSLM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fslm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fslm_pkg;

	localparam int DEF_ENTRIES = 10;
	localparam logic [15:0] MIN_PACKET_BYTES = 16'd8;

	typedef enum logic [1:0] {
		REQ_PACKET  = 2'd0,
		REQ_ENABLE  = 2'd1,
		REQ_DISABLE = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		STS_SHORT       = 4'd0,
		STS_UNKNOWN     = 4'd1,
		STS_FIRST       = 4'd2,
		STS_IN_SEQ      = 4'd3,
		STS_GAP         = 4'd4,
		STS_ENABLED     = 4'd5,
		STS_ALREADY     = 4'd6,
		STS_FULL        = 4'd7,
		STS_EN_REFUSED  = 4'd8,
		STS_DISABLED    = 4'd9,
		STS_DIS_REFUSED = 4'd10,
		STS_NOT_FOUND   = 4'd11,
		STS_CLEARED     = 4'd12,
		STS_CLR_MISSING = 4'd13
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_UPD  = 2'b10
	} state_t;

	typedef struct packed {
		logic [31:0] last_seq;
		logic [31:0] rx;
		logic [31:0] in_order;
		logic [31:0] missing;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/flow_sequence_loss_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "flow_sequence_loss_monitor_defines.svh"

// Per-flow sequence loss monitor. A request is a packet (flow id, sequence number, length)
// or a command that enables, disables or clears a flow in a table of ENTRIES flows; every
// request gives exactly one result with a status, the entry's slot and its counters after
// the update. In the cycle a request is accepted the flow id is matched against all
// entries and the counter memory is read; in the update state that follows, the entry is
// updated and written back. The result sits in an output register, so a waiting result
// does not block the next request from being accepted, but that request's write-back waits
// until the output register is free. No clearing pass is needed after reset.
module flow_sequence_loss_monitor
	import fslm_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output      logic        req_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] flow_id,
	input  wire logic [31:0] sequence_number,
	input  wire logic [15:0] packet_length,
	input  wire logic        partner_accepts,
	output      logic        rsp_valid,
	input  wire logic        rsp_stall,
	output      logic [3:0]  status,
	output      logic [3:0]  slot,
	output      logic [31:0] received_total,
	output      logic [31:0] in_sequence_total,
	output      logic [31:0] missing_total,
	output      logic [31:0] gap_size
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	state_t state_q;

	logic [ENTRIES-1:0] active_q;
	logic [ENTRIES-1:0] seen_q;
	logic [ENTRIES-1:0] cnt_ok_q;
	logic [31:0]        flow_q [ENTRIES];

	entry_t mem [ENTRIES];

	logic             take;
	logic             hit;
	logic             free;
	logic [IDX_W-1:0] hidx;
	logic [IDX_W-1:0] fidx;

	req_t             req_s1;
	logic [31:0]      flow_s1;
	logic [31:0]      seq_s1;
	logic             short_s1;
	logic             acc_s1;
	logic             hit_s1;
	logic             free_s1;
	logic [IDX_W-1:0] hidx_s1;
	logic [IDX_W-1:0] fidx_s1;
	entry_t           rd_s1;

	entry_t           cur;
	entry_t           nw;
	entry_t           wr_data;
	logic             wr_en;
	logic [IDX_W-1:0] e_idx;
	logic [31:0]      gap;
	logic             out_free;
	logic             upd_go;
	status_t          o_status;
	logic             o_zero;
	logic [31:0]      o_gap;
	logic             upd_active;
	logic             act_val;
	logic             upd_flow;
	logic [31:0]      flow_val;
	logic             upd_seen;
	logic             seen_val;

	logic        rsp_valid_q;
	status_t     status_q;
	logic [3:0]  slot_q;
	logic [31:0] rx_q;
	logic [31:0] ino_q;
	logic [31:0] miss_q;
	logic [31:0] gap_q;

	assign req_stall = (state_q != S_IDLE);
	assign take      = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign upd_go    = (state_q == S_UPD) && out_free;

	// id match and first free entry, lowest index wins
	always_comb begin
		hit  = 1'b0;
		free = 1'b0;
		hidx = '0;
		fidx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if ((flow_q[i] == flow_id) &&
			    (active_q[i] || (req_t'(req_type) == REQ_CLEAR))) begin
				hit  = 1'b1;
				hidx = IDX_W'(i);
			end
			if (!active_q[i]) begin
				free = 1'b1;
				fidx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1   <= req_t'(req_type);
			flow_s1  <= flow_id;
			seq_s1   <= sequence_number;
			short_s1 <= (packet_length < MIN_PACKET_BYTES);
			acc_s1   <= partner_accepts;
			hit_s1   <= hit;
			free_s1  <= free;
			hidx_s1  <= hidx;
			fidx_s1  <= fidx;
			rd_s1    <= mem[hidx];
		end
		if (upd_go && wr_en) begin
			mem[e_idx] <= wr_data;
		end
	end

	// counters of a never written entry read as zero
	always_comb begin
		cur = rd_s1;
		if (!cnt_ok_q[hidx_s1]) begin
			cur.rx       = '0;
			cur.in_order = '0;
			cur.missing  = '0;
		end
	end

	assign gap = seq_s1 - cur.last_seq - 32'd1;

	always_comb begin
		nw         = cur;
		wr_en      = 1'b0;
		wr_data    = cur;
		e_idx      = hidx_s1;
		o_status   = STS_SHORT;
		o_zero     = 1'b1;
		o_gap      = '0;
		upd_active = 1'b0;
		act_val    = 1'b0;
		upd_flow   = 1'b0;
		flow_val   = flow_s1;
		upd_seen   = 1'b0;
		seen_val   = 1'b0;
		unique case (req_s1)
			REQ_PACKET: begin
				if (short_s1) begin
					o_status = STS_SHORT;
				end else if (!hit_s1) begin
					o_status = STS_UNKNOWN;
				end else begin
					nw.rx       = cur.rx + 32'd1;
					nw.last_seq = seq_s1;
					wr_en       = 1'b1;
					o_zero      = 1'b0;
					upd_seen    = 1'b1;
					seen_val    = 1'b1;
					if (!seen_q[hidx_s1]) begin
						o_status = STS_FIRST;
					end else if (gap == 32'd0) begin
						nw.in_order = cur.in_order + 32'd1;
						o_status    = STS_IN_SEQ;
					end else begin
						nw.missing = cur.missing + gap;
						o_gap      = gap;
						o_status   = STS_GAP;
					end
					wr_data = nw;
				end
			end
			REQ_ENABLE: begin
				if (hit_s1) begin
					o_status = STS_ALREADY;
					o_zero   = 1'b0;
				end else if (!free_s1) begin
					o_status = STS_FULL;
				end else begin
					e_idx      = fidx_s1;
					wr_en      = 1'b1;
					wr_data    = '0;
					nw         = '0;
					o_zero     = 1'b0;
					upd_seen   = 1'b1;
					upd_active = 1'b1;
					act_val    = acc_s1;
					upd_flow   = 1'b1;
					flow_val   = acc_s1 ? flow_s1 : 32'd0;
					o_status   = acc_s1 ? STS_ENABLED : STS_EN_REFUSED;
				end
			end
			REQ_DISABLE: begin
				if (!hit_s1) begin
					o_status = STS_NOT_FOUND;
				end else begin
					o_zero = 1'b0;
					if (acc_s1) begin
						upd_active = 1'b1;
						o_status   = STS_DISABLED;
					end else begin
						o_status = STS_DIS_REFUSED;
					end
				end
			end
			REQ_CLEAR: begin
				if (!hit_s1) begin
					o_status = STS_CLR_MISSING;
				end else begin
					nw.rx       = '0;
					nw.in_order = '0;
					nw.missing  = '0;
					wr_en       = 1'b1;
					wr_data     = nw;
					o_zero      = 1'b0;
					o_status    = STS_CLEARED;
				end
			end
			default: begin
				o_status = STS_SHORT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			seen_q   <= '0;
			cnt_ok_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				flow_q[i] <= '0;
			end
		end else if (upd_go) begin
			if (wr_en) begin
				cnt_ok_q[e_idx] <= 1'b1;
			end
			if (upd_seen) begin
				seen_q[e_idx] <= seen_val;
			end
			if (upd_active) begin
				active_q[e_idx] <= act_val;
			end
			if (upd_flow) begin
				flow_q[e_idx] <= flow_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (upd_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			status_q <= o_status;
			slot_q   <= o_zero ? 4'd0 : 4'(e_idx);
			rx_q     <= o_zero ? 32'd0 : nw.rx;
			ino_q    <= o_zero ? 32'd0 : nw.in_order;
			miss_q   <= o_zero ? 32'd0 : nw.missing;
			gap_q    <= o_gap;
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign status            = status_q;
	assign slot              = slot_q;
	assign received_total    = rx_q;
	assign in_sequence_total = ino_q;
	assign missing_total     = miss_q;
	assign gap_size          = gap_q;

	`FSLM_ASSERT_NEXT(a_take_to_upd, take, state_q == S_UPD, "accepted request did not start update")
	`FSLM_ASSERT_NEXT(a_upd_holds, (state_q == S_UPD) && !out_free,
		(state_q == S_UPD) && $stable(hidx_s1) && $stable(req_s1),
		"update step lost its request while the result register was busy")
	`FSLM_ASSERT_NOW(a_no_entry_zero, rsp_valid_q && (status_q == STS_SHORT ||
		status_q == STS_UNKNOWN || status_q == STS_FULL || status_q == STS_NOT_FOUND ||
		status_q == STS_CLR_MISSING), slot_q == 4'd0 && rx_q == 32'd0 && miss_q == 32'd0,
		"result without an entry carries entry data")
	`FSLM_ASSERT_NOW(a_gap_only_on_gap, rsp_valid_q && status_q != STS_GAP, gap_q == 32'd0,
		"gap reported on a result that is not a gap")
	`FSLM_ASSERT_NEXT(a_load_sets_valid, upd_go, rsp_valid_q, "result register not loaded")

endmodule

`default_nettype wire
